>>> hdl/pwmm_pkg.sv
// ----------------------------------------------------------------------------
// pwmm_pkg: shared types and constants of the PWM period and duty meter
// Field widths, register indexes and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmm_pkg;

  localparam int CLK_HZ_W   = 26;   // width of the clock_hz register
  localparam int GAP_W      = 24;   // width of the gap_ticks register
  localparam int CFG_DATA_W = 26;   // widest register
  localparam int CFG_IDX_W  = 1;
  localparam int PERIOD_W   = 16;   // result period and frequency fields
  localparam int DUTY_W     = 7;
  localparam int DUTY_SCALE = 100;
  localparam int DUTY_STEPS = 7;    // quotient bits of the duty division
  localparam int FREQ_STEPS = CLK_HZ_W;
  localparam int STEP_W     = 5;

  localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RESET  = CLK_HZ_W'(8000000);
  localparam logic [GAP_W-1:0]    GAP_TICKS_RESET = GAP_W'(400000);

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS = 1'b1;

  typedef struct packed {
    logic accept;        // a sample is transferred this cycle
    logic tick_adv;      // measurement counter moves on
    logic tick_restart;  // new measurement: this sample is tick zero
    logic cap_rise;
    logic cap_fall;
    logic cap_end;       // third capture: latch period and high time
    logic gap_clear;
    logic gap_inc;
    logic div_init;
    logic div_step;
    logic out_load;
  } pwmm_cmd_t;

  typedef struct packed {
    logic rising;
    logic falling;
    logic order_ok;
    logic gap_done;
    logic div_last;
    logic out_free;
  } pwmm_sts_t;

endpackage

`default_nettype wire

>>> hdl/pwmm_if.sv
// ----------------------------------------------------------------------------
// pwmm_if: sample and result channels of the PWM meter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwmm_in_if import pwmm_pkg::*; ();
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface pwmm_out_if import pwmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period_ticks;
  logic [PERIOD_W-1:0] frequency_hz;
  logic [DUTY_W-1:0]   duty_percent;

  modport source (output valid, output period_ticks, output frequency_hz,
                  output duty_percent, input ready);
  modport sink   (input valid, input period_ticks, input frequency_hz,
                  input duty_percent, output ready);
endinterface

`default_nettype wire

>>> hdl/pwmm_ctrl.sv
// ----------------------------------------------------------------------------
// pwmm_ctrl: measurement sequencer
// Steps through the three captures, the idle gap and the division, and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmm_ctrl import pwmm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pwmm_sts_t sts,
  output pwmm_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_RISE1 = 7'b0000001,
    S_FALL  = 7'b0000010,
    S_RISE2 = 7'b0000100,
    S_GAP   = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_RISE1) || (state_r == S_FALL) ||
                    (state_r == S_RISE2) || (state_r == S_GAP);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = accept;
    case (state_r)
      S_RISE1: begin
        if (accept) begin
          cmd.tick_adv = 1'b1;
          if (sts.rising) begin
            cmd.cap_rise = 1'b1;
            state_nxt    = S_FALL;
          end
        end
      end
      S_FALL: begin
        if (accept) begin
          cmd.tick_adv = 1'b1;
          if (sts.falling) begin
            cmd.cap_fall = 1'b1;
            state_nxt    = S_RISE2;
          end
        end
      end
      S_RISE2: begin
        if (accept) begin
          cmd.tick_adv = 1'b1;
          if (sts.rising) begin
            cmd.gap_clear = 1'b1;
            // Captures out of order after a counter wrap give no result.
            if (sts.order_ok) begin
              cmd.cap_end = 1'b1;
              state_nxt   = S_LOAD;
            end else begin
              state_nxt = S_GAP;
            end
          end
        end
      end
      S_GAP: begin
        if (accept) begin
          if (sts.gap_done) begin
            cmd.tick_restart = 1'b1;
            if (sts.rising) begin
              cmd.cap_rise = 1'b1;
              state_nxt    = S_FALL;
            end else begin
              state_nxt = S_RISE1;
            end
          end else begin
            cmd.gap_inc = 1'b1;
          end
        end
      end
      S_LOAD: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_GAP;
        end
      end
      default: begin
        state_nxt = S_RISE1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RISE1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pwmm_dp.sv
// ----------------------------------------------------------------------------
// pwmm_dp: capture, gap and division datapath of the PWM meter
// Edge detection, the tick counter, capture registers, the gap counter, the
// configuration registers, a bit-serial divider pair and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmm_dp import pwmm_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_level,
  input  wire pwmm_cmd_t             cmd,
  output pwmm_sts_t                  sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PERIOD_W-1:0]        out_period_ticks,
  output logic [PERIOD_W-1:0]        out_frequency_hz,
  output logic [DUTY_W-1:0]          out_duty_percent
);

  localparam int TW    = TIMER_WIDTH;
  localparam int DW    = TIMER_WIDTH + DUTY_W;      // duty dividend width
  localparam int SAT_W = TIMER_WIDTH + PERIOD_W;

  logic [CLK_HZ_W-1:0] clock_hz_r;
  logic [GAP_W-1:0]    gap_ticks_r;
  logic                prev_r;
  logic [TW-1:0]       tick_r, rise_r, fall_r, period_r, diff_r;
  logic [GAP_W-1:0]    gap_r;
  logic [TW-1:0]       now;

  logic [TW-1:0]       frem_r;
  logic [CLK_HZ_W-1:0] fquo_r;
  logic [DW-1:0]       drem_r, dvs_r;
  logic [DUTY_W-1:0]   dquo_r;
  logic [STEP_W-1:0]   step_r;

  logic [TW:0]         fsh;
  logic                fge, dge, duty_on;
  logic [SAT_W-1:0]    per_ext;

  logic                out_valid_r;
  logic [PERIOD_W-1:0] out_period_r, out_freq_r;
  logic [DUTY_W-1:0]   out_duty_r;

  // A restarting measurement counts the current sample as tick zero.
  assign now = cmd.tick_restart ? '0 : tick_r;

  assign sts.rising   = in_level && !prev_r;
  assign sts.falling  = !in_level && prev_r;
  assign sts.order_ok = (rise_r < fall_r) && (fall_r < now);
  assign sts.gap_done = (gap_r >= gap_ticks_r);
  assign sts.div_last = (step_r == STEP_W'(FREQ_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Frequency: restoring division, one quotient bit per cycle.
  assign fsh = {frem_r, fquo_r[CLK_HZ_W-1]};
  assign fge = (fsh >= {1'b0, period_r});

  // Duty: quotient is below 100, so seven steps against a shifted divisor.
  assign dge     = (drem_r >= dvs_r);
  assign duty_on = (step_r < STEP_W'(DUTY_STEPS));

  assign per_ext = SAT_W'(period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= CLOCK_HZ_RESET;
      gap_ticks_r <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_HZ:  clock_hz_r  <= cfg_data[CLK_HZ_W-1:0];
        CFG_GAP_TICKS: gap_ticks_r <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      tick_r <= '0;
      rise_r <= '0;
      fall_r <= '0;
      gap_r  <= '0;
    end else begin
      if (cmd.accept) begin
        prev_r <= in_level;
      end
      if (cmd.tick_restart) begin
        tick_r <= TW'(1);
      end else if (cmd.tick_adv) begin
        tick_r <= tick_r + TW'(1);
      end
      if (cmd.cap_rise) begin
        rise_r <= now;
      end
      if (cmd.cap_fall) begin
        fall_r <= now;
      end
      if (cmd.gap_clear) begin
        gap_r <= '0;
      end else if (cmd.gap_inc) begin
        gap_r <= gap_r + GAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_end) begin
      period_r <= now - rise_r;
      diff_r   <= fall_r - rise_r;
    end
    if (cmd.div_init) begin
      frem_r <= '0;
      fquo_r <= clock_hz_r;
      drem_r <= DW'(diff_r) * DW'(DUTY_SCALE);
      dvs_r  <= DW'(period_r) << (DUTY_STEPS - 1);
      dquo_r <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      frem_r <= fge ? TW'(fsh - {1'b0, period_r}) : fsh[TW-1:0];
      fquo_r <= {fquo_r[CLK_HZ_W-2:0], fge};
      if (duty_on) begin
        if (dge) begin
          drem_r <= drem_r - dvs_r;
        end
        dquo_r <= {dquo_r[DUTY_W-2:0], dge};
        dvs_r  <= dvs_r >> 1;
      end
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_period_r <= (per_ext > SAT_W'({PERIOD_W{1'b1}})) ? '1 : per_ext[PERIOD_W-1:0];
      out_freq_r   <= (fquo_r > CLK_HZ_W'({PERIOD_W{1'b1}})) ? '1 : fquo_r[PERIOD_W-1:0];
      out_duty_r   <= dquo_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_ticks = out_period_r;
  assign out_frequency_hz = out_freq_r;
  assign out_duty_percent = out_duty_r;

endmodule

`default_nettype wire

>>> hdl/pwm_period_duty_meter.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_meter: PWM period, frequency and duty meter
// Input capture of a sampled signal with a bit-serial divider pair for the results.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one tick of the measured signal. A
// measurement times the first rising edge, the following falling edge and the
// next rising edge; if the three captures are in order it produces one result
// with the period, clock_hz divided by the period (saturated) and the duty in
// percent, then idles for gap_ticks samples. Samples are taken one per cycle
// while measuring and idling. After a third capture that yields a result the
// input is held off through one load state, 26 division steps of the serial
// divider pair and the write of the result register, and for as long as the
// previous result still waits in the output register. Configuration writes
// are meant for an idle block.
`default_nettype none

module pwm_period_duty_meter import pwmm_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  pwmm_in_if.sink                    in_chan,
  pwmm_out_if.source                 out_chan
);

  pwmm_cmd_t cmd;
  pwmm_sts_t sts;

  pwmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwmm_dp #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_level         (in_chan.level),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_period_ticks (out_chan.period_ticks),
    .out_frequency_hz (out_chan.frequency_hz),
    .out_duty_percent (out_chan.duty_percent)
  );

endmodule

`default_nettype wire
